FILE: hdl/bls_pkg.sv
package bls_pkg;

  // Default coordinate width; the top level hands it down as COORD_BITS.
  localparam int COORD_BITS_DEF = 12;

  // RGB565 colour word.
  localparam int COLOR_BITS = 16;

  // Input item kinds.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

endpackage

FILE: hdl/bls_in_if.sv
interface bls_in_if #(
  parameter int CoordBits = bls_pkg::COORD_BITS_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic                                 mode;
  logic signed [CoordBits-1:0]          x_start;
  logic signed [CoordBits-1:0]          x_end;
  logic signed [CoordBits-1:0]          y_start;
  logic signed [CoordBits-1:0]          y_end;
  logic        [bls_pkg::COLOR_BITS-1:0] color;

  modport source (
    output valid, mode, x_start, x_end, y_start, y_end, color,
    input  ready
  );

  modport sink (
    input  valid, mode, x_start, x_end, y_start, y_end, color,
    output ready
  );
endinterface

FILE: hdl/bls_out_if.sv
interface bls_out_if #(
  parameter int CoordBits = bls_pkg::COORD_BITS_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic signed [CoordBits-1:0]          pixel_x;
  logic signed [CoordBits-1:0]          pixel_y;
  logic        [bls_pkg::COLOR_BITS-1:0] pixel_color;
  logic                                 last;
  logic                                 valid_res;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last, valid_res,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last, valid_res,
    output ready
  );
endinterface

FILE: hdl/bresenham_line_stepper.sv
// Channel   Direction  Handshake      Payload
// in_chan   sink       valid / ready  mode, x_start, x_end, y_start, y_end, color
// out_chan  source     valid / ready  pixel_x, pixel_y, pixel_color, last, valid_res
//
// Every input transaction yields exactly one output transaction, via the stage-one
// and output registers; one per cycle is sustained when the output is not stalled.
// The stage-one register holds the line setup, the stage-two logic steps the line
// state and fills the output register; the error update is the longest path.
// rst_n is synchronous and active low; it clears the stage valids and ends any line.
// A stalled output holds its result while one more input transaction is taken.
module bresenham_line_stepper #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bls_in_if.sink    in_chan,
  bls_out_if.source out_chan
);

  localparam int W = COORD_BITS;
  localparam int C = bls_pkg::COLOR_BITS;

  // Line setup worked out from the endpoints alone, so it can be registered
  // before the line state is touched.
  typedef struct packed {
    logic                 mode;
    logic signed [W-1:0]  major_start;
    logic signed [W-1:0]  major_stop;
    logic signed [W-1:0]  minor_start;
    logic        [W-1:0]  major_span;
    logic        [W-1:0]  minor_span;
    logic                 minor_down;
    logic                 steep;
    logic        [C-1:0]  color;
  } setup_t;

  // ------------------------------------------------------------------------
  // Handshake. Stage one empties into the output register whenever that
  // register is empty or being read, so a new input transaction can enter
  // in the same cycle.
  // ------------------------------------------------------------------------
  logic   s1_valid_r;
  setup_t s1_r;
  setup_t s1_nxt;
  logic   out_valid_r;
  logic   s1_take;
  logic   in_fire;

  assign s1_take       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_take;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // ------------------------------------------------------------------------
  // Stage one: spans, steepness, axis swap and endpoint ordering.
  // ------------------------------------------------------------------------
  logic signed [W:0]   dx;
  logic signed [W:0]   dy;
  logic        [W-1:0] adx;
  logic        [W-1:0] ady;
  logic                steep;
  logic signed [W-1:0] a0;
  logic signed [W-1:0] a1;
  logic signed [W-1:0] b0;
  logic signed [W-1:0] b1;
  logic                reorder;

  always_comb begin
    dx  = {in_chan.x_end[W-1], in_chan.x_end} - {in_chan.x_start[W-1], in_chan.x_start};
    dy  = {in_chan.y_end[W-1], in_chan.y_end} - {in_chan.y_start[W-1], in_chan.y_start};
    adx = dx[W] ? W'(-dx) : dx[W-1:0];
    ady = dy[W] ? W'(-dy) : dy[W-1:0];
    // Equal spans count as shallow, so x stays the major axis.
    steep = ady > adx;

    if (steep) begin
      a0 = in_chan.y_start;
      a1 = in_chan.y_end;
      b0 = in_chan.x_start;
      b1 = in_chan.x_end;
    end else begin
      a0 = in_chan.x_start;
      a1 = in_chan.x_end;
      b0 = in_chan.y_start;
      b1 = in_chan.y_end;
    end

    // Walk the major axis upward; swap the endpoints when it falls.
    reorder = a0 > a1;

    s1_nxt.mode        = in_chan.mode;
    s1_nxt.major_start = reorder ? a1 : a0;
    s1_nxt.major_stop  = reorder ? a0 : a1;
    s1_nxt.minor_start = reorder ? b1 : b0;
    s1_nxt.major_span  = steep ? ady : adx;
    s1_nxt.minor_span  = steep ? adx : ady;
    // The minor coordinate moves down unless the ordered far end lies above.
    s1_nxt.minor_down  = reorder ? !(b1 < b0) : !(b0 < b1);
    s1_nxt.steep       = steep;
    s1_nxt.color       = in_chan.color;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
  end

  // ------------------------------------------------------------------------
  // Stage two: line state and pixel emission. A start transaction takes its
  // working values from stage one, a step transaction from the line state.
  // ------------------------------------------------------------------------
  logic signed [W-1:0] major_pos_r,  major_pos_nxt;
  logic signed [W-1:0] major_stop_r, major_stop_nxt;
  logic signed [W-1:0] minor_pos_r,  minor_pos_nxt;
  logic signed [W:0]   error_r,      error_nxt;
  logic        [W-1:0] major_span_r, major_span_nxt;
  logic        [W-1:0] minor_span_r, minor_span_nxt;
  logic                minor_down_r, minor_down_nxt;
  logic                steep_r,      steep_nxt;
  logic        [C-1:0] color_r,      color_nxt;
  logic                busy_r,       busy_nxt;

  logic signed [W-1:0] pixel_x_r,     pixel_x_nxt;
  logic signed [W-1:0] pixel_y_r,     pixel_y_nxt;
  logic        [C-1:0] pixel_color_r, pixel_color_nxt;
  logic                last_r,        last_nxt;
  logic                valid_res_r,   valid_res_nxt;

  logic                is_start;
  logic                emit;
  logic                fin;
  logic signed [W-1:0] cur_major;
  logic signed [W-1:0] cur_stop;
  logic signed [W-1:0] cur_minor;
  logic signed [W:0]   cur_error;
  logic        [W-1:0] cur_major_span;
  logic        [W-1:0] cur_minor_span;
  logic                cur_down;
  logic                cur_steep;
  logic        [C-1:0] cur_color;
  logic signed [W:0]   error_dec;

  always_comb begin
    is_start = s1_r.mode == bls_pkg::MODE_START;
    emit     = is_start || busy_r;

    cur_major      = is_start ? s1_r.major_start : major_pos_r;
    cur_stop       = is_start ? s1_r.major_stop  : major_stop_r;
    cur_minor      = is_start ? s1_r.minor_start : minor_pos_r;
    // A new line starts its error at half the major span, rounded down.
    cur_error      = is_start ? $signed({2'b00, s1_r.major_span[W-1:1]}) : error_r;
    cur_major_span = is_start ? s1_r.major_span  : major_span_r;
    cur_minor_span = is_start ? s1_r.minor_span  : minor_span_r;
    cur_down       = is_start ? s1_r.minor_down  : minor_down_r;
    cur_steep      = is_start ? s1_r.steep       : steep_r;
    cur_color      = is_start ? s1_r.color       : color_r;

    fin       = cur_major == cur_stop;
    error_dec = cur_error - $signed({1'b0, cur_minor_span});

    // Hold everything unless a pixel is emitted.
    major_pos_nxt  = major_pos_r;
    major_stop_nxt = major_stop_r;
    minor_pos_nxt  = minor_pos_r;
    error_nxt      = error_r;
    major_span_nxt = major_span_r;
    minor_span_nxt = minor_span_r;
    minor_down_nxt = minor_down_r;
    steep_nxt      = steep_r;
    color_nxt      = color_r;
    busy_nxt       = busy_r;

    // A step with no line in progress reports an empty result.
    pixel_x_nxt     = '0;
    pixel_y_nxt     = '0;
    pixel_color_nxt = '0;
    last_nxt        = 1'b0;
    valid_res_nxt   = 1'b0;

    if (emit) begin
      pixel_x_nxt     = cur_steep ? cur_minor : cur_major;
      pixel_y_nxt     = cur_steep ? cur_major : cur_minor;
      pixel_color_nxt = cur_color;
      last_nxt        = fin;
      valid_res_nxt   = 1'b1;

      major_pos_nxt  = cur_major;
      major_stop_nxt = cur_stop;
      minor_pos_nxt  = cur_minor;
      error_nxt      = cur_error;
      major_span_nxt = cur_major_span;
      minor_span_nxt = cur_minor_span;
      minor_down_nxt = cur_down;
      steep_nxt      = cur_steep;
      color_nxt      = cur_color;
      busy_nxt       = !fin;

      // Advance to the next pixel unless this one ends the line.
      if (!fin) begin
        major_pos_nxt = cur_major + W'(1);
        if (error_dec[W]) begin
          minor_pos_nxt = cur_down ? cur_minor - W'(1) : cur_minor + W'(1);
          error_nxt     = error_dec + $signed({1'b0, cur_major_span});
        end else begin
          error_nxt = error_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_take) begin
        busy_r      <= busy_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (s1_take) begin
      major_pos_r   <= major_pos_nxt;
      major_stop_r  <= major_stop_nxt;
      minor_pos_r   <= minor_pos_nxt;
      error_r       <= error_nxt;
      major_span_r  <= major_span_nxt;
      minor_span_r  <= minor_span_nxt;
      minor_down_r  <= minor_down_nxt;
      steep_r       <= steep_nxt;
      color_r       <= color_nxt;
      pixel_x_r     <= pixel_x_nxt;
      pixel_y_r     <= pixel_y_nxt;
      pixel_color_r <= pixel_color_nxt;
      last_r        <= last_nxt;
      valid_res_r   <= valid_res_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.pixel_x     = pixel_x_r;
  assign out_chan.pixel_y     = pixel_y_r;
  assign out_chan.pixel_color = pixel_color_r;
  assign out_chan.last        = last_r;
  assign out_chan.valid_res   = valid_res_r;

endmodule

FILE: tb/tb_bresenham_line_stepper.sv
module tb_bresenham_line_stepper;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB          = bls_pkg::COORD_BITS_DEF;
  localparam int CLR_BITS    = bls_pkg::COLOR_BITS;
  localparam int COORD_MAX   = 2 ** (CB - 1) - 1;
  localparam int COORD_MIN   = -(2 ** (CB - 1));
  // Generous ceiling on the run, in cycles.
  localparam int CYCLE_LIMIT = 200000;
  // The receiver goes quiet for this long once, while the sender keeps offering.
  localparam int HOLD_CYCLES = 300;

  // One input transaction: either a line start or a one-pixel advance.
  typedef struct {
    logic                    mode;
    logic signed [CB-1:0]    x_start;
    logic signed [CB-1:0]    x_end;
    logic signed [CB-1:0]    y_start;
    logic signed [CB-1:0]    y_end;
    logic [CLR_BITS-1:0]     color;
  } line_item_t;

  // One output transaction: a pixel, or a not-valid answer to a stray step.
  typedef struct {
    logic signed [CB-1:0]    pixel_x;
    logic signed [CB-1:0]    pixel_y;
    logic [CLR_BITS-1:0]     pixel_color;
    logic                    last;
    logic                    valid_res;
  } pixel_t;

  logic clk;
  logic rst_n;

  bls_in_if  #(.CoordBits(CB)) in_bus ();
  bls_out_if #(.CoordBits(CB)) out_bus ();

  bresenham_line_stepper #(.COORD_BITS(CB)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  always #6 clk = ~clk;

  // Stimulus waiting to be driven, and pixels the rasterizer model says must come out.
  line_item_t line_items[$];
  pixel_t     pending_pixels[$];
  line_item_t cur_item;

  int stim_total;
  int sent_count;
  int got_count;
  int lines_done;
  int stray_steps;
  int mismatches;
  int cycle_count;
  int hold_left;
  int hold_mark;
  bit hold_done;

  // Rasterizer model state. It mirrors the block after reset: no line in progress.
  int              r_major_pos;
  int              r_major_stop;
  int              r_minor_pos;
  int              r_error;
  int              r_major_span;
  int              r_minor_span;
  bit              r_minor_down;
  bit              r_steep;
  logic [CLR_BITS-1:0] r_color;
  bit              r_busy;

  function automatic int abs_gap(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Produce the pixel at the current position and move the line state one step
  // along the major axis. The final pixel ends the line instead of stepping.
  function automatic pixel_t emit_pixel();
    pixel_t px;
    bit     fin;
    fin = (r_major_pos == r_major_stop);
    if (r_steep) begin
      px.pixel_x = r_minor_pos[CB-1:0];
      px.pixel_y = r_major_pos[CB-1:0];
    end else begin
      px.pixel_x = r_major_pos[CB-1:0];
      px.pixel_y = r_minor_pos[CB-1:0];
    end
    px.pixel_color = r_color;
    px.last        = fin;
    px.valid_res   = 1'b1;
    if (fin) begin
      r_busy = 1'b0;
    end else begin
      r_busy      = 1'b1;
      r_major_pos = r_major_pos + 1;
      r_error     = r_error - r_minor_span;
      if (r_error < 0) begin
        r_minor_pos = r_minor_pos + (r_minor_down ? -1 : 1);
        r_error     = r_error + r_major_span;
      end
    end
    return px;
  endfunction

  // Work out the output transaction that one accepted input transaction causes.
  function automatic pixel_t rasterize(line_item_t it);
    pixel_t px;
    int     a0;
    int     a1;
    int     b0;
    int     b1;
    int     t;
    px.pixel_x     = '0;
    px.pixel_y     = '0;
    px.pixel_color = '0;
    px.last        = 1'b0;
    px.valid_res   = 1'b0;
    if (it.mode == bls_pkg::MODE_START) begin
      a0 = $signed(it.x_start);
      a1 = $signed(it.x_end);
      b0 = $signed(it.y_start);
      b1 = $signed(it.y_end);
      // Equal spans keep x as the major axis; only a strictly taller line swaps.
      r_steep = abs_gap(b1, b0) > abs_gap(a1, a0);
      if (r_steep) begin
        t = a0; a0 = b0; b0 = t;
        t = a1; a1 = b1; b1 = t;
      end
      // Walk the major axis upward.
      if (a0 > a1) begin
        t = a0; a0 = a1; a1 = t;
        t = b0; b0 = b1; b1 = t;
      end
      r_major_pos  = a0;
      r_major_stop = a1;
      r_minor_pos  = b0;
      r_major_span = a1 - a0;
      r_minor_span = abs_gap(b1, b0);
      r_error      = r_major_span / 2;
      r_minor_down = !(b0 < b1);
      r_color      = it.color;
      px = emit_pixel();
    end else if (r_busy) begin
      px = emit_pixel();
    end
    return px;
  endfunction

  // A step transaction; its coordinate and color fields are ignored by the block,
  // so they carry random values to exercise every bit.
  task automatic add_step();
    line_item_t it;
    it.mode    = bls_pkg::MODE_STEP;
    it.x_start = CB'($urandom);
    it.x_end   = CB'($urandom);
    it.y_start = CB'($urandom);
    it.y_end   = CB'($urandom);
    it.color   = CLR_BITS'($urandom);
    line_items.push_back(it);
  endtask

  // A line start followed by a given number of step transactions.
  task automatic add_line(int x0, int y0, int x1, int y1, int col, int steps);
    line_item_t it;
    it.mode    = bls_pkg::MODE_START;
    it.x_start = x0[CB-1:0];
    it.x_end   = x1[CB-1:0];
    it.y_start = y0[CB-1:0];
    it.y_end   = y1[CB-1:0];
    it.color   = col[CLR_BITS-1:0];
    line_items.push_back(it);
    repeat (steps) add_step();
  endtask

  function automatic int rand_coord();
    return int'($urandom_range(0, 2 ** CB - 1)) + COORD_MIN;
  endfunction

  // A second endpoint a short random distance away, reflected back if it would
  // leave the coordinate range.
  function automatic int near_coord(int base);
    int d;
    d = int'($urandom_range(0, 24));
    if ($urandom_range(0, 1) == 1) d = -d;
    if (base + d > COORD_MAX || base + d < COORD_MIN) d = -d;
    return base + d;
  endfunction

  task automatic compare_field(string field, int expected, int actual);
    if (expected != actual) begin
      $error("%s: expected %0d, got %0d", field, expected, actual);
      mismatches++;
    end
  endtask

  // Driver. A transaction is offered until the block takes it; the model is run
  // on it at the edge where valid and ready are both high. The sender idles in
  // the first third of the run at 36 percent, in the second at 46, then never.
  always @(posedge clk) begin
    logic take;
    int   idle_pct;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      take = !in_bus.valid;
      if (in_bus.valid && in_bus.ready) begin
        pending_pixels.push_back(rasterize(cur_item));
        sent_count++;
        take = 1'b1;
      end
      if (sent_count * 3 < stim_total) begin
        idle_pct = 36;
      end else if (sent_count * 3 < stim_total * 2) begin
        idle_pct = 46;
      end else begin
        idle_pct = 0;
      end
      if (take) begin
        if (line_items.size() > 0 && int'($urandom_range(0, 99)) >= idle_pct) begin
          cur_item = line_items.pop_front();
          in_bus.valid   <= 1'b1;
          in_bus.mode    <= cur_item.mode;
          in_bus.x_start <= cur_item.x_start;
          in_bus.x_end   <= cur_item.x_end;
          in_bus.y_start <= cur_item.y_start;
          in_bus.y_end   <= cur_item.y_end;
          in_bus.color   <= cur_item.color;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold, timed here on its own. Once three quarters of the
  // pixels are back, the monitor keeps ready low while hold_left counts down from HOLD_CYCLES.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && got_count >= hold_mark) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end
  end

  // Monitor. Each output transaction is checked against the oldest predicted
  // pixel. The receiver stalls at 46 percent, then 36, then not at all, and once,
  // in the stall-free part, holds ready low long enough to back up the input.
  always @(posedge clk) begin
    pixel_t want;
    int     stall_pct;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got_count++;
        if (pending_pixels.size() == 0) begin
          $error("output transaction with no pixel predicted: x %0d y %0d",
                 out_bus.pixel_x, out_bus.pixel_y);
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          compare_field("pixel_x", want.pixel_x, out_bus.pixel_x);
          compare_field("pixel_y", want.pixel_y, out_bus.pixel_y);
          compare_field("pixel_color", want.pixel_color, out_bus.pixel_color);
          compare_field("last", want.last, out_bus.last);
          compare_field("valid_res", want.valid_res, out_bus.valid_res);
          if (!want.valid_res) stray_steps++;
          if (want.valid_res && want.last) lines_done++;
        end
      end
      if (got_count * 3 < stim_total) begin
        stall_pct = 46;
      end else if (got_count * 3 < stim_total * 2) begin
        stall_pct = 36;
      end else begin
        stall_pct = 0;
      end
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= (int'($urandom_range(0, 99)) >= stall_pct);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int pick;
    int x0;
    int y0;
    int x1;
    int y1;
    int len;
    int steps;

    clk            = 1'b0;
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.mode    = bls_pkg::MODE_START;
    in_bus.x_start = '0;
    in_bus.x_end   = '0;
    in_bus.y_start = '0;
    in_bus.y_end   = '0;
    in_bus.color   = '0;
    out_bus.ready  = 1'b0;

    // Directed part. A step before any line must come back not valid.
    add_step();
    // A single-point line finishes on its start pixel; the next step is stray.
    add_line(5, 5, 5, 5, 'h1234, 1);
    // Flat line given right to left at the top of the range.
    add_line(COORD_MAX, 0, COORD_MAX - 3, 0, 'hF800, 3);
    // Equal spans: x stays the major axis and y falls.
    add_line(0, 0, -3, 3, 'h07E0, 3);
    // A steep line from the bottom of the row range.
    add_line(0, COORD_MIN, 1, COORD_MIN + 4, 'h001F, 4);
    // Full-range diagonals; the second start drops the first line mid-way.
    add_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 'hFFFF, 2);
    add_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 'h0000, 2);
    // Vertical line walked downward, which reorders the endpoints.
    add_line(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX - 2, 'hAAAA, 2);

    // Random part: mostly complete short lines, some cut off by a new start,
    // some long lines that are abandoned, stray steps, and single points.
    while (line_items.size() < 2025) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 75) begin
        x0 = rand_coord();
        y0 = rand_coord();
        x1 = near_coord(x0);
        y1 = near_coord(y0);
        len = abs_gap(x1, x0) > abs_gap(y1, y0) ? abs_gap(x1, x0) : abs_gap(y1, y0);
        if ($urandom_range(0, 9) == 0) begin
          steps = int'($urandom_range(0, len));
        end else begin
          steps = len + int'($urandom_range(0, 2));
        end
        add_line(x0, y0, x1, y1, int'($urandom_range(0, 65535)), steps);
      end else if (pick < 85) begin
        add_line(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 int'($urandom_range(0, 65535)), int'($urandom_range(0, 8)));
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 3)) add_step();
      end else begin
        x0 = rand_coord();
        y0 = rand_coord();
        add_line(x0, y0, x0, y0, int'($urandom_range(0, 65535)),
                 int'($urandom_range(0, 1)));
      end
    end
    stim_total = line_items.size();
    hold_mark  = (stim_total * 3) / 4;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_count < stim_total || pending_pixels.size() != 0) @(posedge clk);
    // The pipeline is two deep; a few more cycles catch any extra output.
    repeat (10) @(posedge clk);

    $display("Drove %0d transactions and checked %0d pixels in %0d cycles.",
             sent_count, got_count, cycle_count);
    $display("%0d lines ran to their last pixel; %0d steps arrived with no line active.",
             lines_done, stray_steps);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
